// ===== hdl/tilemap_register_run_decoder_macros.svh =====
// Assertion macros shared by the tilemap run decoder checkers.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef TILEMAP_REGISTER_RUN_DECODER_MACROS_SVH
`define TILEMAP_REGISTER_RUN_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TMRD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tmrd same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define TMRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tmrd next-cycle check failed");

`endif

// ===== hdl/tmrd_pkg.sv =====
// Package for the tilemap register run decoder: payload types, codes and
// controller/datapath interface structs. Depends on nothing.
`timescale 1ns / 1ps

package tmrd_pkg;

   localparam int LANE_COUNT = 4;
   localparam int REG_COUNT  = 4;
   localparam int REG_IDX_W  = 2;
   localparam int POS_W      = 23;
   localparam int RUN_W      = 9;

   // Command opcodes (bits 15..12 of a command word).
   localparam logic [3:0] OP_XOR_HI   = 4'd0;
   localparam logic [3:0] OP_XOR_LO   = 4'd1;
   localparam logic [3:0] OP_RUN_FLAT = 4'd12;
   localparam logic [3:0] OP_RUN_UP   = 4'd13;
   localparam logic [3:0] OP_RUN_DOWN = 4'd15;

   typedef enum logic [1:0] {
      PH_NONE    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_COMMAND = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUNNING = 2'd0,
      ST_DONE    = 2'd1,
      ST_ERROR   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      STEP_HOLD = 2'd0,
      STEP_UP   = 2'd1,
      STEP_DOWN = 2'd2
   } step_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_RUN  = 2'd2
   } state_type;

   typedef struct packed {
      logic [15:0] stream_word;
      logic        start_of_stream;
   } req_type;

   typedef struct packed {
      logic [15:0] tile_lane0;
      logic [15:0] tile_lane1;
      logic [15:0] tile_lane2;
      logic [15:0] tile_lane3;
      logic [2:0]  lane_count;
      logic        run_last;
      logic        stream_done;
      logic        format_error;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic exec;
      logic run_load;
      logic run_beat;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic run_ok;
      logic run_final;
      logic out_free;
   } stat_type;

endpackage

// ===== hdl/tmrd_ctrl.sv =====
// Controller state machine for the tilemap run decoder.
// Depends on tmrd_pkg; drives datapath commands from datapath status.
`timescale 1ns / 1ps

module tmrd_ctrl
   import tmrd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (stat.run_ok) begin
               state_in = S_RUN;
            end else if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_RUN: begin
            if (stat.out_free && stat.run_final) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            // No request is taken while reset is high.
            req_stall = reset;
            cmd.take  = req_valid && !reset;
         end
         S_EXEC: begin
            cmd.run_load = stat.run_ok;
            cmd.exec     = !stat.run_ok && stat.out_free;
         end
         S_RUN: begin
            cmd.run_beat = stat.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== hdl/tmrd_dpath.sv =====
// Datapath for the tilemap run decoder: value registers, header and position
// state, run generator and output register. Depends on tmrd_pkg.
`timescale 1ns / 1ps

module tmrd_dpath
   import tmrd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  logic     rsp_stall,
   output logic     rsp_valid,
   output rsp_type  rsp_data,
   input  cmd_type  cmd,
   output stat_type stat
);

   // Latched request.
   logic [15:0] word_ff;
   logic        sos_ff;

   // Architectural state.
   logic [15:0] regs_ff [REG_COUNT];
   logic [15:0] regs_in [REG_COUNT];
   phase_type   phase_ff, phase_in;
   status_type  status_ff, status_in;
   logic [POS_W-1:0] size_ff, size_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   // Run generator state.
   logic [RUN_W-1:0]     run_left_ff, run_left_in;
   logic [15:0]          run_val_ff, run_val_in;
   step_type             run_step_ff, run_step_in;
   logic [REG_IDX_W-1:0] run_dst_ff, run_dst_in;

   // Output register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Command word fields.
   logic [3:0]           op;
   logic [REG_IDX_W-1:0] src;
   logic [REG_IDX_W-1:0] dst;
   logic [7:0]           operand;
   logic [RUN_W-1:0]     count;
   logic                 is_run_op;
   logic                 run_fits;
   logic [POS_W:0]       size_bytes;
   logic [POS_W-1:0]     size_hdr;
   step_type             step_kind;

   // Run beat values.
   logic [15:0] lane_val [LANE_COUNT+1];
   logic [2:0]  beat_n;
   logic        beat_last;

   assign op         = word_ff[15:12];
   assign src        = word_ff[11:10];
   assign dst        = word_ff[9:8];
   assign operand    = word_ff[7:0];
   assign count      = {1'b0, operand} + RUN_W'(1);
   assign size_bytes = {word_ff, size_ff[7:0]};
   assign size_hdr   = size_bytes[POS_W:1];
   assign is_run_op = (op == OP_RUN_FLAT) || (op == OP_RUN_UP) || (op == OP_RUN_DOWN);
   assign run_fits  = ({1'b0, pos_ff} + 24'(count)) <= {1'b0, size_ff};

   // A command is a run that goes to the generator only if it fits the size.
   assign stat.run_ok = !sos_ff && (phase_ff == PH_COMMAND) &&
                        (status_ff == ST_RUNNING) && is_run_op && run_fits;
   assign stat.run_final = run_left_ff <= RUN_W'(LANE_COUNT);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (op == OP_RUN_UP) begin
         step_kind = STEP_UP;
      end else if (op == OP_RUN_DOWN) begin
         step_kind = STEP_DOWN;
      end else begin
         step_kind = STEP_HOLD;
      end
   end

   // Lane values of the current beat, plus the value after the beat.
   always_comb begin
      for (int i = 0; i <= LANE_COUNT; i++) begin
         unique case (run_step_ff)
            STEP_UP:   lane_val[i] = run_val_ff + 16'(i);
            STEP_DOWN: lane_val[i] = run_val_ff - 16'(i);
            default:   lane_val[i] = run_val_ff;
         endcase
      end
   end

   assign beat_last = run_left_ff <= RUN_W'(LANE_COUNT);
   assign beat_n    = beat_last ? run_left_ff[2:0] : 3'(LANE_COUNT);

   // Next-state logic for execute, run load and run beats.
   always_comb begin
      logic [15:0] lanes [LANE_COUNT];
      for (int i = 0; i < REG_COUNT; i++) regs_in[i] = regs_ff[i];
      for (int i = 0; i < LANE_COUNT; i++) lanes[i] = 16'd0;
      phase_in     = phase_ff;
      status_in    = status_ff;
      size_in      = size_ff;
      pos_in       = pos_ff;
      run_left_in  = run_left_ff;
      run_val_in   = run_val_ff;
      run_step_in  = run_step_ff;
      run_dst_in   = run_dst_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      if (cmd.exec) begin
         // Single-beat items: header words, register updates, errors, ignores.
         priority if (sos_ff) begin
            for (int i = 0; i < REG_COUNT; i++) regs_in[i] = 16'd0;
            pos_in    = '0;
            status_in = ST_RUNNING;
            size_in   = POS_W'(word_ff[15:8]);
            phase_in  = PH_HEADER;
         end else if (phase_ff == PH_HEADER) begin
            size_in  = size_hdr;
            phase_in = PH_COMMAND;
            if (pos_ff >= size_hdr) status_in = ST_DONE;
         end else if (phase_ff == PH_COMMAND && status_ff == ST_RUNNING) begin
            if (op == OP_XOR_HI) begin
               regs_in[dst] = regs_ff[src] ^ {operand, 8'h00};
            end else if (op == OP_XOR_LO) begin
               regs_in[dst] = regs_ff[src] ^ {8'h00, operand};
            end else begin
               // Bad opcode, or a run that would pass the declared size.
               status_in = ST_ERROR;
            end
         end else begin
            // Words before any stream, or after done or error, change nothing.
         end
         rsp_valid_in = 1'b1;
         rsp_in.tile_lane0   = 16'd0;
         rsp_in.tile_lane1   = 16'd0;
         rsp_in.tile_lane2   = 16'd0;
         rsp_in.tile_lane3   = 16'd0;
         rsp_in.lane_count   = 3'd0;
         rsp_in.run_last     = 1'b1;
         rsp_in.stream_done  = status_in == ST_DONE;
         rsp_in.format_error = status_in == ST_ERROR;
      end

      if (cmd.run_load) begin
         run_val_in  = regs_ff[src];
         run_left_in = count;
         run_step_in = step_kind;
         run_dst_in  = dst;
      end

      if (cmd.run_beat) begin
         // One beat of up to four words; the last beat writes the destination.
         for (int i = 0; i < LANE_COUNT; i++) begin
            lanes[i] = (3'(i) < beat_n) ? lane_val[i] : 16'd0;
         end
         pos_in      = pos_ff + POS_W'(beat_n);
         run_left_in = run_left_ff - RUN_W'(beat_n);
         run_val_in  = lane_val[beat_n];
         if (beat_last) begin
            regs_in[run_dst_ff] = lane_val[beat_n];
            if (pos_in >= size_ff) status_in = ST_DONE;
         end
         rsp_valid_in = 1'b1;
         rsp_in.tile_lane0   = lanes[0];
         rsp_in.tile_lane1   = lanes[1];
         rsp_in.tile_lane2   = lanes[2];
         rsp_in.tile_lane3   = lanes[3];
         rsp_in.lane_count   = beat_n;
         rsp_in.run_last     = beat_last;
         rsp_in.stream_done  = status_in == ST_DONE;
         rsp_in.format_error = 1'b0;
      end
   end

   // Request latch and payload registers.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         word_ff <= req_data.stream_word;
         sos_ff  <= req_data.start_of_stream;
      end
      run_left_ff <= run_left_in;
      run_val_ff  <= run_val_in;
      run_step_ff <= run_step_in;
      run_dst_ff  <= run_dst_in;
      rsp_ff      <= rsp_in;
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) regs_ff[i] <= 16'd0;
         phase_ff     <= PH_NONE;
         status_ff    <= ST_RUNNING;
         size_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < REG_COUNT; i++) regs_ff[i] <= regs_in[i];
         phase_ff     <= phase_in;
         status_ff    <= status_in;
         size_ff      <= size_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/tilemap_register_run_decoder.sv =====
// Tilemap register run decoder: one request is one 16-bit stream word and
// yields one or more four-lane response beats. A request is latched when it
// is accepted and executed once the response register is free, so header
// words, XOR commands, ignored and faulty words give one beat; a run of
// operand+1 words gives ceil((operand+1)/4) beats from the run generator,
// one beat per cycle while the response is not stalled. The response register
// holds a finished beat while the next request is accepted.
`timescale 1ns / 1ps

module tilemap_register_run_decoder
   import tmrd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   tmrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Decoder state, run generator and response register.
   tmrd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ===== hdl/tmrd_checker.sv =====
// Port-level checker for the tilemap run decoder, bound to the top level.
// Depends on tmrd_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "tilemap_register_run_decoder_macros.svh"

module tmrd_checker
   import tmrd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled response holds its beat.
   `TMRD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Only the last beat of a request may be partly filled.
   `TMRD_ASSERT_NOW(a_full_beats, clock, reset, rsp_valid && !rsp_data.run_last, rsp_data.lane_count == 3'd4)

   // Lane count never exceeds the number of lanes.
   `TMRD_ASSERT_NOW(a_lane_range, clock, reset, rsp_valid, rsp_data.lane_count <= 3'd4)

   // An error beat carries no words and no done flag.
   `TMRD_ASSERT_NOW(a_err_empty, clock, reset, rsp_valid && rsp_data.format_error, rsp_data.lane_count == 3'd0 && !rsp_data.stream_done)

   // Requests are taken one at a time; the next cycle always stalls.
   `TMRD_ASSERT_NEXT(a_req_single, clock, reset, req_valid && !req_stall, req_stall)

endmodule

bind tilemap_register_run_decoder tmrd_checker u_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the tilemap register run decoder: a queue-fed
// request driver, a response monitor and a request-level decoder predictor.
// Depends on tmrd_pkg and the tilemap_register_run_decoder top level.
`timescale 1ns / 1ps

module testbench;
   import tmrd_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 185;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 200;
   // An opcode with no meaning to the decoder.
   localparam logic [3:0] OP_SPARE = 4'd14;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Requests waiting to be driven and beats waiting to be seen.
   req_type pending_words [$];
   rsp_type tile_beats [$];

   // Predictor copy of the decoder state.
   logic [15:0] tile_regs [REG_COUNT];
   phase_type   hdr_phase;
   logic [22:0] size_words;
   logic [22:0] out_pos;
   status_type  strm_status;

   // Handshake bookkeeping shared between the clocked processes.
   bit      req_taken = 1'b0;
   bit      rsp_taken = 1'b0;
   bit      rsp_hold = 1'b0;
   int      req_gap = 0;
   int      rsp_wait = 0;
   int      req_calm = 0;
   int      rsp_calm = 0;
   int      hold_left = 0;
   int      seen_reqs = 0;
   int      cycles = 0;
   int      error_count = 0;
   rsp_type want_beat;
   int      bad_fields;

   tilemap_register_run_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic logic [15:0] make_cmd(input logic [3:0] op, input logic [1:0] src,
                                            input logic [1:0] dst, input logic [7:0] operand);
      return {op, src, dst, operand};
   endfunction

   // Wait in cycles before the next request or response; calm stretches have none.
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm_left = $urandom_range(10, 30);
         return 0;
      end
      return ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 11)) : 0;
   endfunction

   function automatic rsp_type pack_beat(input logic [LANE_COUNT-1:0][15:0] lanes,
                                         input int unsigned fill, input status_type status);
      rsp_type b;
      b = '0;
      if (fill > 0) b.tile_lane0 = lanes[0];
      if (fill > 1) b.tile_lane1 = lanes[1];
      if (fill > 2) b.tile_lane2 = lanes[2];
      if (fill > 3) b.tile_lane3 = lanes[3];
      b.lane_count   = 3'(fill);
      b.stream_done  = (status == ST_DONE);
      b.format_error = (status == ST_ERROR);
      return b;
   endfunction

   // Decode one stream word and queue the beats it should produce.
   task automatic decode_word(input req_type r);
      logic [15:0] w;
      logic [3:0]  op;
      logic [1:0]  src;
      logic [1:0]  dst;
      logic [7:0]  operand;
      logic [23:0] size24;
      logic [15:0] v;
      logic [15:0] stride;
      logic [LANE_COUNT-1:0][15:0] lanes;
      int unsigned count;
      int unsigned fill;
      rsp_type     item_beats [$];
      w = r.stream_word;
      lanes = '0;
      if (r.start_of_stream) begin
         foreach (tile_regs[k]) tile_regs[k] = '0;
         out_pos = '0;
         strm_status = ST_RUNNING;
         size_words = {15'd0, w[15:8]};
         hdr_phase = PH_HEADER;
      end else if (hdr_phase == PH_HEADER) begin
         size24 = {w, size_words[7:0]};
         size_words = size24[23:1];
         hdr_phase = PH_COMMAND;
         if (out_pos >= size_words) strm_status = ST_DONE;
      end else if (hdr_phase == PH_COMMAND && strm_status == ST_RUNNING) begin
         op = w[15:12];
         src = w[11:10];
         dst = w[9:8];
         operand = w[7:0];
         case (op)
            OP_XOR_HI: begin
               tile_regs[dst] = tile_regs[src] ^ {operand, 8'h00};
            end
            OP_XOR_LO: begin
               tile_regs[dst] = tile_regs[src] ^ {8'h00, operand};
            end
            OP_RUN_FLAT, OP_RUN_UP, OP_RUN_DOWN: begin
               count = operand + 1;
               stride = (op == OP_RUN_FLAT) ? 16'h0000 :
                        (op == OP_RUN_UP) ? 16'h0001 : 16'hFFFF;
               if (out_pos + count > size_words) begin
                  strm_status = ST_ERROR;
               end else begin
                  // Words go out four to a beat; the last beat may be partial.
                  v = tile_regs[src];
                  fill = 0;
                  for (int unsigned i = 0; i < count; i++) begin
                     lanes[fill] = v;
                     fill++;
                     v = v + stride;
                     out_pos = out_pos + 1'b1;
                     if (fill == LANE_COUNT || i + 1 == count) begin
                        if (out_pos >= size_words) strm_status = ST_DONE;
                        item_beats.push_back(pack_beat(lanes, fill, strm_status));
                        fill = 0;
                     end
                  end
                  tile_regs[dst] = v;
               end
            end
            default: begin
               strm_status = ST_ERROR;
            end
         endcase
      end
      // A request that emits no words still yields one empty beat.
      if (item_beats.size() == 0) item_beats.push_back(pack_beat(lanes, 0, strm_status));
      item_beats[item_beats.size() - 1].run_last = 1'b1;
      foreach (item_beats[k]) tile_beats.push_back(item_beats[k]);
   endtask

   function automatic int field_bad(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   task automatic offer(input logic [15:0] word, input logic sos);
      req_type r;
      r.stream_word = word;
      r.start_of_stream = sos;
      pending_words.push_back(r);
   endtask

   // Request driver: presents queued requests, holding each until accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_data <= pending_words.pop_front();
            req_valid <= 1'b1;
            req_gap = draw_wait(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side: random stalls per beat, plus the long hold when asked.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_taken) rsp_wait = draw_wait(rsp_calm);
         rsp_stall <= rsp_hold || (rsp_wait > 0);
         if (rsp_wait > 0) rsp_wait--;
      end
   end

   // Long response hold, started twice at fixed request counts so the
   // decoder backs up and stalls its requests.
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         seen_reqs = 0;
      end else begin
         if (hold_left > 0) hold_left--;
         if (req_valid && !req_stall) begin
            seen_reqs++;
            if (seen_reqs == 40 || seen_reqs == 150) hold_left = HOLD_CYCLES;
         end
      end
      rsp_hold = (hold_left > 0);
   end

   // Monitor: predict on each accepted request, check each accepted beat.
   always @(posedge clock) begin
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (reset) begin
         foreach (tile_regs[k]) tile_regs[k] = '0;
         hdr_phase = PH_NONE;
         size_words = '0;
         out_pos = '0;
         strm_status = ST_RUNNING;
         tile_beats.delete();
      end else begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            decode_word(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            if (tile_beats.size() == 0) begin
               $display("%0t: beat with nothing expected, expected none, got %p",
                        $time, rsp_data);
               error_count++;
            end else begin
               want_beat = tile_beats.pop_front();
               bad_fields = 0;
               bad_fields += field_bad("tile_lane0", want_beat.tile_lane0, rsp_data.tile_lane0);
               bad_fields += field_bad("tile_lane1", want_beat.tile_lane1, rsp_data.tile_lane1);
               bad_fields += field_bad("tile_lane2", want_beat.tile_lane2, rsp_data.tile_lane2);
               bad_fields += field_bad("tile_lane3", want_beat.tile_lane3, rsp_data.tile_lane3);
               bad_fields += field_bad("lane_count", want_beat.lane_count, rsp_data.lane_count);
               bad_fields += field_bad("run_last", want_beat.run_last, rsp_data.run_last);
               bad_fields += field_bad("stream_done", want_beat.stream_done,
                                       rsp_data.stream_done);
               bad_fields += field_bad("format_error", want_beat.format_error,
                                       rsp_data.format_error);
               if (bad_fields != 0) error_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // Stimulus and end of test.
   initial begin
      logic [7:0]  hi_byte;
      logic [15:0] w1;
      logic [15:0] word;
      logic [23:0] size24;
      logic [3:0]  run_op;
      logic [7:0]  operand;
      int unsigned gen_size;
      int unsigned gen_pos;
      int unsigned room;
      bit          gen_open;
      int          live_items;
      int          sel;

      // Directed part: command before any stream, both XORs, all run kinds,
      // wraparound, overrun, sticky error and done, zero size, exact fill,
      // restart during the header, largest size and an unknown opcode.
      offer(make_cmd(OP_RUN_UP, 2'd3, 2'd3, 8'hFF), 1'b0);
      offer(16'hFF5A, 1'b1);
      offer(16'h0001, 1'b0);
      offer(make_cmd(OP_XOR_HI, 2'd0, 2'd1, 8'hFF), 1'b0);
      offer(make_cmd(OP_XOR_LO, 2'd1, 2'd2, 8'hFF), 1'b0);
      offer(make_cmd(OP_RUN_FLAT, 2'd2, 2'd0, 8'h00), 1'b0);
      offer(make_cmd(OP_RUN_UP, 2'd2, 2'd3, 8'h06), 1'b0);
      offer(make_cmd(OP_RUN_DOWN, 2'd1, 2'd1, 8'h04), 1'b0);
      offer(make_cmd(OP_RUN_DOWN, 2'd0, 2'd0, 8'hFF), 1'b0);
      offer(make_cmd(OP_XOR_LO, 2'd0, 2'd0, 8'h01), 1'b0);
      offer(16'h00FF, 1'b1);
      offer(16'h0000, 1'b0);
      offer(make_cmd(OP_RUN_FLAT, 2'd1, 2'd2, 8'h03), 1'b0);
      offer(16'h0400, 1'b1);
      offer(16'h0000, 1'b0);
      offer(make_cmd(OP_RUN_UP, 2'd0, 2'd1, 8'h01), 1'b0);
      offer(16'hFF00, 1'b1);
      offer(16'h08C3, 1'b1);
      offer(16'h0002, 1'b0);
      offer(make_cmd(OP_XOR_HI, 2'd3, 2'd2, 8'h5A), 1'b0);
      offer(make_cmd(OP_RUN_FLAT, 2'd2, 2'd0, 8'hFF), 1'b0);
      offer(make_cmd(OP_RUN_UP, 2'd0, 2'd3, 8'h03), 1'b0);
      offer(16'hFFFF, 1'b1);
      offer(16'hFFFF, 1'b0);
      offer(make_cmd(OP_SPARE, 2'd3, 2'd2, 8'hA5), 1'b0);

      // Random part: mostly well-formed streams of small size, with restarts,
      // bad opcodes, overruns and stray words mixed in.
      gen_open = 1'b0;
      gen_size = 0;
      gen_pos = 0;
      live_items = 0;
      while (live_items < RANDOM_ITEMS) begin
         if ((!gen_open && $urandom_range(0, 3) != 0) || $urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 9) == 0) begin
               offer(16'($urandom), 1'b1);
               live_items++;
            end
            hi_byte = 8'($urandom);
            offer({hi_byte, 8'($urandom)}, 1'b1);
            w1 = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
            offer(w1, 1'b0);
            size24 = {w1, hi_byte};
            gen_size = size24[23:1];
            gen_pos = 0;
            gen_open = (gen_size != 0);
            live_items += 2;
         end else if (!gen_open) begin
            // Stream finished: the decoder ignores this word.
            offer(16'($urandom), 1'b0);
            live_items++;
         end else begin
            sel = $urandom_range(0, 99);
            live_items++;
            if (sel < 40) begin
               run_op = ($urandom_range(0, 1) == 0) ? OP_XOR_HI : OP_XOR_LO;
               offer(make_cmd(run_op, 2'($urandom), 2'($urandom), 8'($urandom)), 1'b0);
            end else if (sel < 88) begin
               case ($urandom_range(0, 2))
                  0: run_op = OP_RUN_FLAT;
                  1: run_op = OP_RUN_UP;
                  default: run_op = OP_RUN_DOWN;
               endcase
               room = gen_size - gen_pos;
               if ($urandom_range(0, 4) == 0 && room >= 1 && room <= 256)
                  operand = 8'(room - 1);
               else if ($urandom_range(0, 11) == 0)
                  operand = 8'($urandom);
               else
                  operand = 8'($urandom_range(0, 15));
               offer(make_cmd(run_op, 2'($urandom), 2'($urandom), operand), 1'b0);
               if (gen_pos + operand + 1 > gen_size) begin
                  gen_open = 1'b0;
               end else begin
                  gen_pos += operand + 1;
                  if (gen_pos >= gen_size) gen_open = 1'b0;
               end
            end else if (sel < 94) begin
               run_op = ($urandom_range(0, 3) == 0) ? OP_SPARE : 4'($urandom_range(2, 11));
               offer(make_cmd(run_op, 2'($urandom), 2'($urandom), 8'($urandom)), 1'b0);
               gen_open = 1'b0;
            end else begin
               word = 16'($urandom);
               offer(word, 1'b0);
               if (word[15:12] != OP_XOR_HI && word[15:12] != OP_XOR_LO) gen_open = 1'b0;
            end
         end
      end

      // Let reset run its course, then wait for all requests and beats.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_words.size() != 0 || req_valid) @(negedge clock);
      while (tile_beats.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (tile_beats.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, tile_beats.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
